// ===== rtl/pld_pkg.sv =====
// ----------------------------------------------------------------------------
// pld_pkg
// Shared types and constants of the postings list decoder: opcodes, record
// kinds, register indexes and the entry that travels from front to back.
// ----------------------------------------------------------------------------
package pld_pkg;

   localparam int DEL_INDEX_W       = 10;   // width of a bitmap word index
   localparam int DEL_WORD_W        = 64;   // documents per bitmap word
   localparam int BIT_INDEX_W       = 6;    // bit within a bitmap word
   localparam int VARINT_MAX_GROUPS = 5;    // 7-bit groups that land in 32 bits
   localparam int QUEUE_DEPTH       = 4;
   localparam int QUEUE_PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W       = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_BYTE       = 2'd0,
      OP_DEL_WORD   = 2'd1,
      OP_START_TERM = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      KIND_DOC      = 2'd0,
      KIND_POS      = 2'd1,
      KIND_TERM_END = 2'd2
   } kind_type;

   localparam logic [1:0] CSR_FIELD_BOOST = 2'd0;
   localparam logic [1:0] CSR_POS_BOOST   = 2'd1;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] doc;
      logic [31:0] freq;
      logic [7:0]  fboost;
      logic [31:0] pos;
      logic [7:0]  pboost;
      logic        last;
      logic        done;
   } record_type;

   typedef struct packed {
      logic                   is_write;   // bitmap word write
      logic [DEL_INDEX_W-1:0] word;       // write address or lookup word
      logic [DEL_WORD_W-1:0]  wdata;
      logic                   lookup;     // new document, fetch its deletion bit
      logic                   in_range;   // document is covered by the bitmap
      logic [BIT_INDEX_W-1:0] bit_index;
      logic                   has_rec;
      logic                   filter;     // record is dropped for a deleted doc
      record_type             rec;
   } entry_type;

endpackage

// ===== rtl/pld_front.sv =====
// ----------------------------------------------------------------------------
// pld_front
// Accepts request beats, holds the configuration registers and runs the
// byte-level decode state machine, turning each beat into at most one entry.
// ----------------------------------------------------------------------------
module pld_front import pld_pkg::*; #(
   parameter int DELETION_MAP_DOCS = 65536
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [1:0]   req_tuser,
   input  logic [119:0] req_tdata,
   input  logic         csr_valid,
   input  logic [1:0]   csr_index,
   input  logic         csr_wdata,
   input  logic         q_full,
   input  logic         clearing,
   output logic         push,
   output entry_type    push_entry
);

   localparam int DEL_WORDS    = (DELETION_MAP_DOCS + DEL_WORD_W - 1) / DEL_WORD_W;
   localparam int MAX_WORDS    = 2 ** DEL_INDEX_W;
   localparam int MEM_WORDS    = (DEL_WORDS < MAX_WORDS) ? DEL_WORDS : MAX_WORDS;
   localparam int MEM_DOCS     = MEM_WORDS * DEL_WORD_W;
   localparam int LOOKUP_LIMIT = (DELETION_MAP_DOCS < MEM_DOCS) ? DELETION_MAP_DOCS : MEM_DOCS;

   typedef enum logic [5:0] {
      PH_IDLE   = 6'b000001,
      PH_DOC    = 6'b000010,
      PH_FREQ   = 6'b000100,
      PH_FBOOST = 6'b001000,
      PH_POS    = 6'b010000,
      PH_PBOOST = 6'b100000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [31:0] acc_ff, acc_in;
   logic [2:0]  shift_ff, shift_in;
   logic [31:0] doc_ff, doc_in;
   logic [31:0] freq_ff, freq_in;
   logic [31:0] left_ff, left_in;
   logic [31:0] pos_ff, pos_in;
   logic [31:0] seen_ff, seen_in;
   logic [31:0] count_ff, count_in;
   logic [7:0]  fboost_ff, fboost_in;
   logic        sfb_ff, spb_ff;

   op_type                 op;
   logic [7:0]             in_byte;
   logic [31:0]            in_count;
   logic [DEL_INDEX_W-1:0] in_word;
   logic [DEL_WORD_W-1:0]  in_value;
   logic                   accept;

   logic [31:0] vi_part, vi_acc;
   logic        vi_done;
   logic [2:0]  vi_shift;
   logic        freq_step, header_step, pos_step, end_step, last_term;
   kind_type    end_kind;
   logic [31:0] end_pos;
   logic [7:0]  end_pboost, pboost_val;
   entry_type   ent;
   logic        ent_valid;

   assign op       = op_type'(req_tuser);
   assign in_byte  = req_tdata[7:0];
   assign in_count = req_tdata[39:8];
   assign in_word  = req_tdata[49:40];
   assign in_value = req_tdata[113:50];

   assign req_tready = !q_full && !clearing;
   assign accept     = req_tvalid && req_tready;

   // one 7-bit group per byte, groups past the fifth are dropped
   always_comb begin
      unique case (shift_ff)
         3'd0:    vi_part = {25'd0, in_byte[6:0]};
         3'd1:    vi_part = {18'd0, in_byte[6:0], 7'd0};
         3'd2:    vi_part = {11'd0, in_byte[6:0], 14'd0};
         3'd3:    vi_part = {4'd0, in_byte[6:0], 21'd0};
         3'd4:    vi_part = {in_byte[3:0], 28'd0};
         default: vi_part = '0;
      endcase
   end

   assign vi_acc   = acc_ff | vi_part;
   assign vi_done  = !in_byte[7];
   assign vi_shift = (shift_ff < 3'(VARINT_MAX_GROUPS)) ? shift_ff + 3'd1 : shift_ff;
   assign last_term = (seen_ff == count_ff);

   always_comb begin
      phase_in    = phase_ff;
      acc_in      = acc_ff;
      shift_in    = shift_ff;
      doc_in      = doc_ff;
      freq_in     = freq_ff;
      left_in     = left_ff;
      pos_in      = pos_ff;
      seen_in     = seen_ff;
      count_in    = count_ff;
      fboost_in   = fboost_ff;
      ent         = '0;
      ent_valid   = 1'b0;
      freq_step   = 1'b0;
      header_step = 1'b0;
      pos_step    = 1'b0;
      end_step    = 1'b0;
      end_kind    = KIND_DOC;
      end_pos     = '0;
      end_pboost  = '0;
      pboost_val  = '0;

      if (accept) begin
         unique case (op)
            OP_DEL_WORD: begin
               if ({1'b0, in_word} < (DEL_INDEX_W + 1)'(MEM_WORDS)) begin
                  ent_valid    = 1'b1;
                  ent.is_write = 1'b1;
                  ent.word     = in_word;
                  ent.wdata    = in_value;
               end
            end
            OP_START_TERM: begin
               count_in  = in_count;
               seen_in   = '0;
               doc_in    = '0;
               freq_in   = '0;
               pos_in    = '0;
               left_in   = '0;
               fboost_in = '0;
               acc_in    = '0;
               shift_in  = '0;
               if (in_count == '0) begin
                  phase_in      = PH_IDLE;
                  ent_valid     = 1'b1;
                  ent.has_rec   = 1'b1;
                  ent.rec.kind  = KIND_TERM_END;
                  ent.rec.done  = 1'b1;
               end else begin
                  phase_in = PH_DOC;
               end
            end
            OP_BYTE: begin
               unique case (phase_ff)
                  PH_DOC, PH_FREQ, PH_POS: begin
                     acc_in   = vi_done ? '0 : vi_acc;
                     shift_in = vi_done ? '0 : vi_shift;
                     if (vi_done) begin
                        unique case (phase_ff)
                           PH_DOC: begin
                              doc_in        = doc_ff + {1'b0, vi_acc[31:1]};
                              seen_in       = seen_ff + 32'd1;
                              ent_valid     = 1'b1;
                              ent.lookup    = 1'b1;
                              ent.in_range  = (doc_in < 32'(LOOKUP_LIMIT));
                              ent.word      = doc_in[BIT_INDEX_W +: DEL_INDEX_W];
                              ent.bit_index = doc_in[BIT_INDEX_W-1:0];
                              if (vi_acc[0]) begin
                                 freq_in   = 32'd1;
                                 freq_step = 1'b1;
                              end else begin
                                 phase_in = PH_FREQ;
                              end
                           end
                           PH_FREQ: begin
                              freq_in   = vi_acc;
                              freq_step = 1'b1;
                           end
                           default: begin
                              pos_in = pos_ff + vi_acc;
                              if (spb_ff) begin
                                 phase_in = PH_PBOOST;
                              end else begin
                                 pos_step = 1'b1;
                              end
                           end
                        endcase
                     end
                  end
                  PH_FBOOST: begin
                     fboost_in   = in_byte;
                     header_step = 1'b1;
                  end
                  PH_PBOOST: begin
                     pboost_val = in_byte;
                     pos_step   = 1'b1;
                  end
                  default: begin
                     // bytes outside a term are dropped
                  end
               endcase
            end
            default: begin
               // unused opcode
            end
         endcase
      end

      if (freq_step) begin
         if (sfb_ff) begin
            phase_in = PH_FBOOST;
         end else begin
            fboost_in   = '0;
            header_step = 1'b1;
         end
      end

      if (header_step) begin
         left_in = freq_in;
         pos_in  = '0;
         if (freq_in == '0) begin
            end_step = 1'b1;
            end_kind = KIND_DOC;
         end else begin
            phase_in     = PH_POS;
            ent_valid    = 1'b1;
            ent.has_rec  = 1'b1;
            ent.filter   = 1'b1;
            ent.rec.kind = KIND_DOC;
         end
      end

      if (pos_step) begin
         left_in = left_ff - 32'd1;
         if (left_in == '0) begin
            end_step   = 1'b1;
            end_kind   = KIND_POS;
            end_pos    = pos_in;
            end_pboost = pboost_val;
         end else begin
            phase_in       = PH_POS;
            ent_valid      = 1'b1;
            ent.has_rec    = 1'b1;
            ent.filter     = 1'b1;
            ent.rec.kind   = KIND_POS;
            ent.rec.pos    = pos_in;
            ent.rec.pboost = pboost_val;
         end
      end

      // final byte of a document
      if (end_step) begin
         phase_in       = last_term ? PH_IDLE : PH_DOC;
         ent_valid      = 1'b1;
         ent.has_rec    = 1'b1;
         ent.filter     = 1'b1;
         ent.rec.kind   = end_kind;
         ent.rec.pos    = end_pos;
         ent.rec.pboost = end_pboost;
         ent.rec.last   = 1'b1;
         ent.rec.done   = last_term;
      end

      if (ent.filter) begin
         ent.rec.doc    = doc_in;
         ent.rec.freq   = freq_in;
         ent.rec.fboost = fboost_in;
      end
   end

   assign push       = accept && ent_valid;
   assign push_entry = ent;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         sfb_ff   <= 1'b0;
         spb_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         if (csr_valid) begin
            if (csr_index == CSR_FIELD_BOOST) begin
               sfb_ff <= csr_wdata;
            end
            if (csr_index == CSR_POS_BOOST) begin
               spb_ff <= csr_wdata;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      shift_ff  <= shift_in;
      doc_ff    <= doc_in;
      freq_ff   <= freq_in;
      left_ff   <= left_in;
      pos_ff    <= pos_in;
      seen_ff   <= seen_in;
      count_ff  <= count_in;
      fboost_ff <= fboost_in;
   end

endmodule

// ===== rtl/pld_queue.sv =====
// ----------------------------------------------------------------------------
// pld_queue
// Short FIFO of decoded entries between the decode front and the back end.
// ----------------------------------------------------------------------------
module pld_queue import pld_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type head,
   output logic      full,
   output logic      empty
);

   entry_type              slots_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff;

   assign full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slots_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + QUEUE_CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - QUEUE_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("entry pushed into a full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("entry popped from an empty queue");

endmodule

// ===== rtl/pld_back.sv =====
// ----------------------------------------------------------------------------
// pld_back
// Owns the deletion bitmap memory and its clearing pass, resolves deletion
// of each document and drives the response output register.
// ----------------------------------------------------------------------------
module pld_back import pld_pkg::*; #(
   parameter int DELETION_MAP_DOCS = 65536
) (
   input  logic       clock,
   input  logic       reset,
   input  entry_type  head,
   input  logic       q_empty,
   output logic       pop,
   output logic       clearing,
   input  logic       rsp_tready,
   output logic       rsp_valid,
   output record_type rsp_rec
);

   localparam int DEL_WORDS = (DELETION_MAP_DOCS + DEL_WORD_W - 1) / DEL_WORD_W;
   localparam int MAX_WORDS = 2 ** DEL_INDEX_W;
   localparam int MEM_WORDS = (DEL_WORDS < MAX_WORDS) ? DEL_WORDS : MAX_WORDS;
   localparam int AW        = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

   logic [DEL_WORD_W-1:0] mem [MEM_WORDS];
   logic [DEL_WORD_W-1:0] rdata_ff;
   logic                  clr_active_ff;
   logic [AW-1:0]         clr_addr_ff;

   logic                  wen, ren;
   logic [AW-1:0]         waddr;
   logic [DEL_WORD_W-1:0] wdata;

   logic       s1_valid_ff;
   entry_type  s1_ff;
   logic       del_ff;
   logic       out_valid_ff;
   record_type out_rec_ff;

   logic       deleted, kill, s1_emit, out_free, s1_move;
   record_type emit_rec;

   assign clearing = clr_active_ff;

   assign wen   = clr_active_ff || (pop && head.is_write);
   assign waddr = clr_active_ff ? clr_addr_ff : head.word[AW-1:0];
   assign wdata = clr_active_ff ? '0 : head.wdata;
   assign ren   = pop && head.lookup;

   always_ff @(posedge clock) begin
      if (wen) begin
         mem[waddr] <= wdata;
      end
      if (ren) begin
         rdata_ff <= mem[head.word[AW-1:0]];
      end
   end

   // a lookup entry brings its own bit, later records reuse the held one
   assign deleted  = s1_ff.lookup ? (rdata_ff[s1_ff.bit_index] && s1_ff.in_range) : del_ff;
   assign kill     = s1_ff.filter && deleted;
   assign s1_emit  = s1_valid_ff && s1_ff.has_rec && (!kill || s1_ff.rec.done);
   assign out_free = !out_valid_ff || rsp_tready;
   assign s1_move  = s1_valid_ff && (!s1_emit || out_free);
   assign pop      = !q_empty && !clr_active_ff && (!s1_valid_ff || s1_move);

   always_comb begin
      emit_rec = s1_ff.rec;
      if (kill) begin
         emit_rec      = '0;
         emit_rec.kind = KIND_TERM_END;
         emit_rec.done = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
         s1_valid_ff   <= 1'b0;
         del_ff        <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (clr_active_ff) begin
            if (clr_addr_ff == AW'(MEM_WORDS - 1)) begin
               clr_active_ff <= 1'b0;
            end else begin
               clr_addr_ff <= clr_addr_ff + AW'(1);
            end
         end
         if (pop) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move && s1_ff.lookup) begin
            del_ff <= deleted;
         end
         if (s1_move && s1_emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_ff <= head;
      end
      if (s1_move && s1_emit) begin
         out_rec_ff <= emit_rec;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_rec   = out_rec_ff;

   a_idle_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clr_active_ff |-> !s1_valid_ff && !pop)
      else $error("entry in flight during the bitmap clearing pass");
   a_write_no_record: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_ff.is_write |-> !s1_emit)
      else $error("bitmap write entry produced a record");

endmodule

// ===== rtl/postings_list_decoder.sv =====
// ----------------------------------------------------------------------------
// postings_list_decoder
// Decodes a postings byte stream into document and position records, with
// deletion filtering through a word-loaded bitmap.
// ----------------------------------------------------------------------------
// path: an entry passes the queue, the bitmap read stage and the output register
// throughput: one request beat per cycle, set by the byte decode state machine and
//   the single bitmap port, until a stalled response fills the 4-entry queue
// reset: synchronous; afterwards the bitmap is cleared one word per cycle,
//   min(ceil(DELETION_MAP_DOCS/64), 1024) words, with req_tready low
//   (configuration writes are taken throughout)
module postings_list_decoder import pld_pkg::*; #(
   parameter int DELETION_MAP_DOCS = 65536
) (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [1:0]   req_tuser,   // opcode
   input  logic [119:0] req_tdata,   // stream_byte, term_doc_count, del_word_index,
                                     // del_word_value, zero fill
   // response channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [1:0]   rsp_tuser,   // record_kind
   output logic         rsp_tlast,   // last_of_doc
   output logic [119:0] rsp_tdata,   // doc_number, term_frequency, field_boost_value,
                                     // position_value, position_boost_value,
                                     // term_done, zero fill
   // register write channel
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic         csr_wdata
);

   // front to queue
   logic       push;
   entry_type  push_entry;
   // queue to back
   entry_type  head;
   logic       q_full, q_empty, pop;
   // back status
   logic       clearing;
   logic       rsp_valid;
   record_type rsp_rec;

   // registers are plain flops, always writable
   assign csr_ready = 1'b1;

   // decode front: handshake, registers, varint and phase tracking
   pld_front #(
      .DELETION_MAP_DOCS(DELETION_MAP_DOCS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_full     (q_full),
      .clearing   (clearing),
      .push       (push),
      .push_entry (push_entry)
   );

   // decouples decode from bitmap access and response stalls
   pld_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .full       (q_full),
      .empty      (q_empty)
   );

   // back end: bitmap memory, deletion filter, output register
   pld_back #(
      .DELETION_MAP_DOCS(DELETION_MAP_DOCS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_empty    (q_empty),
      .pop        (pop),
      .clearing   (clearing),
      .rsp_tready (rsp_tready),
      .rsp_valid  (rsp_valid),
      .rsp_rec    (rsp_rec)
   );

   // response beat packing, lowest field first
   assign rsp_tvalid = rsp_valid;
   assign rsp_tuser  = rsp_rec.kind;
   assign rsp_tlast  = rsp_rec.last;
   assign rsp_tdata  = {7'd0, rsp_rec.done, rsp_rec.pboost, rsp_rec.pos,
                        rsp_rec.fboost, rsp_rec.freq, rsp_rec.doc};

endmodule
